// ----- rtl/tlbpt_pkg.sv -----
// Shared widths, field positions and types for the TLB and page table translator.
package tlbpt_pkg;

   localparam int ADDR_W      = 16;
   localparam int FRAME_W     = 8;
   localparam int TAG_W       = 8;
   localparam int CNT_W       = 16;
   localparam int FREE_W      = 9;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 56;
   localparam int RSP_USER_W  = 2;

   localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
   localparam logic [FREE_W-1:0] FREE_MAX = '1;

   // Response field positions
   localparam int PHYS_LSB      = 0;
   localparam int FRAME_LSB     = 16;
   localparam int HIT_TOT_LSB   = 24;
   localparam int FAULT_TOT_LSB = 40;
   localparam int USER_HIT      = 0;
   localparam int USER_FAULT    = 1;

   typedef enum logic [3:0] {
      ST_CLEAR   = 4'b0001,
      ST_IDLE    = 4'b0010,
      ST_LOOKUP  = 4'b0100,
      ST_RESOLVE = 4'b1000
   } state_type;

   typedef struct packed {
      logic               present;
      logic [FRAME_W-1:0] frame;
   } pte_type;

endpackage

// ----- rtl/tlbpt_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module tlbpt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/tlb_page_table_translator.sv -----
// Address translator: fully associative TLB with FIFO refill over a demand-paged page table.
//
// req channel carries one logical address per transfer; rsp channel returns one
// translation per request, in order. The upper part of the address selects the
// page, the lower part is the offset (PAGE_SIZE and PAGE_COUNT are powers of two).
// Tags and valid bits sit in flops and are compared in parallel; the TLB frames
// and the page table (present bit plus frame) live in synchronous RAMs.
// Each request passes a lookup state (tag compare, RAM reads issued) and a resolve
// state (read data used, page table and TLB written back, result registered).
// A new request is taken in the resolve state of the previous one, so the lookup of
// one request follows the resolve of the one before and does not overlap it;
// the result register is loaded when the resolve state advances.
// After reset the page table is swept clear, one entry per cycle, all PAGE_COUNT
// entries in turn; req_tready stays low meanwhile.
// The result register waits for rsp_tready; while it is full and stalled, a
// finished translation holds in the resolve state and no further request is taken.
module tlb_page_table_translator #(
   parameter int TLB_ENTRIES = 16,
   parameter int PAGE_COUNT  = 256,
   parameter int PAGE_SIZE   = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [tlbpt_pkg::REQ_DATA_W-1:0]   req_tdata,  // logical_address[15:0]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // physical_address[15:0], frame_number[23:16], hit_total[39:24], fault_total[55:40]
   output logic [tlbpt_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [tlbpt_pkg::RSP_USER_W-1:0]   rsp_tuser   // tlb_hit[0], page_fault[1]
);

   import tlbpt_pkg::*;

   localparam int TI_W  = $clog2(TLB_ENTRIES);
   localparam int PG_W  = $clog2(PAGE_COUNT);
   localparam int OFF_W = $clog2(PAGE_SIZE);
   localparam int PTE_W = $bits(pte_type);

   state_type state_ff, state_in;

   logic [ADDR_W-1:0] addr_ff;
   logic [PG_W-1:0]   page;
   logic [TAG_W-1:0]  tag_now;
   logic [PG_W-1:0]   clr_ff;

   logic [TAG_W-1:0]  tag_ff [TLB_ENTRIES];
   logic              valid_ff [TLB_ENTRIES];
   logic [TI_W-1:0]   fill_ff;
   logic              hit_ff;
   logic [FREE_W-1:0] free_ff;
   logic [CNT_W-1:0]  hit_cnt_ff, hit_cnt_in;
   logic [CNT_W-1:0]  fault_cnt_ff, fault_cnt_in;

   logic              match;
   logic [TI_W-1:0]   match_idx;

   logic              advance;
   logic              req_xfer;
   logic              resolve_go;

   logic [FRAME_W-1:0] tlb_rd_frame;
   logic [PTE_W-1:0]   pt_rd_raw;
   pte_type            pt_rd;
   logic               pt_wr_en;
   logic [PG_W-1:0]    pt_wr_addr;
   pte_type            pt_wr_data;

   logic [FRAME_W-1:0]       frame;
   logic                     fault;
   logic [FRAME_W+OFF_W-1:0] phys_wide;

   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_USER_W-1:0] rsp_user_ff;

   assign page    = PG_W'(addr_ff >> OFF_W);
   assign tag_now = TAG_W'(page);

   // Lowest matching entry wins
   always_comb begin
      match     = 1'b0;
      match_idx = '0;
      for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && tag_ff[i] == tag_now) begin
            match     = 1'b1;
            match_idx = TI_W'(i);
         end
      end
   end

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) || (state_ff == ST_RESOLVE && advance);
   assign req_xfer   = req_tvalid && req_tready;
   assign resolve_go = (state_ff == ST_RESOLVE) && advance;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == PG_W'(PAGE_COUNT - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_xfer) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            state_in = ST_RESOLVE;
         end
         ST_RESOLVE: begin
            if (advance) state_in = req_xfer ? ST_LOOKUP : ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   assign pt_rd = pte_type'(pt_rd_raw);

   // Pick the frame (TLB, page table or free frame), tallies and page table writes
   always_comb begin
      fault = !hit_ff && !pt_rd.present;
      if (hit_ff) begin
         frame = tlb_rd_frame;
      end else if (pt_rd.present) begin
         frame = pt_rd.frame;
      end else begin
         frame = FRAME_W'(free_ff);
      end
      phys_wide = {frame, addr_ff[OFF_W-1:0]};

      hit_cnt_in   = hit_cnt_ff;
      fault_cnt_in = fault_cnt_ff;
      if (hit_ff && hit_cnt_ff != CNT_MAX) hit_cnt_in = hit_cnt_ff + 1'b1;
      if (fault && fault_cnt_ff != CNT_MAX) fault_cnt_in = fault_cnt_ff + 1'b1;

      if (state_ff == ST_CLEAR) begin
         pt_wr_en   = 1'b1;
         pt_wr_addr = clr_ff;
         pt_wr_data = '0;
      end else begin
         pt_wr_en           = resolve_go && fault;
         pt_wr_addr         = page;
         pt_wr_data.present = 1'b1;
         pt_wr_data.frame   = frame;
      end
   end

   tlbpt_ram #(
      .WIDTH (PTE_W),
      .DEPTH (PAGE_COUNT)
   ) u_page_table (
      .clock   (clock),
      .wr_en   (pt_wr_en),
      .wr_addr (pt_wr_addr),
      .wr_data (PTE_W'(pt_wr_data)),
      .rd_en   (state_ff == ST_LOOKUP),
      .rd_addr (page),
      .rd_data (pt_rd_raw)
   );

   tlbpt_ram #(
      .WIDTH (FRAME_W),
      .DEPTH (TLB_ENTRIES)
   ) u_tlb_frames (
      .clock   (clock),
      .wr_en   (resolve_go && !hit_ff),
      .wr_addr (fill_ff),
      .wr_data (frame),
      .rd_en   (state_ff == ST_LOOKUP),
      .rd_addr (match_idx),
      .rd_data (tlb_rd_frame)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         fill_ff      <= '0;
         free_ff      <= '0;
         hit_cnt_ff   <= '0;
         fault_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < TLB_ENTRIES; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (resolve_go) begin
            hit_cnt_ff   <= hit_cnt_in;
            fault_cnt_ff <= fault_cnt_in;
            if (fault && free_ff != FREE_MAX) free_ff <= free_ff + 1'b1;
            if (!hit_ff) begin
               valid_ff[fill_ff] <= 1'b1;
               fill_ff <= (fill_ff == TI_W'(TLB_ENTRIES - 1)) ? '0 : fill_ff + 1'b1;
            end
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) addr_ff <= req_tdata;
      if (state_ff == ST_LOOKUP) hit_ff <= match;
      if (resolve_go) begin
         if (!hit_ff) tag_ff[fill_ff] <= tag_now;
         rsp_data_ff <= {fault_cnt_in, hit_cnt_in, frame, ADDR_W'(phys_wide)};
         rsp_user_ff <= {fault, hit_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ----- rtl/tlbpt_checker.sv -----
// Port-level checks for the translator, bound to the top level.
module tlbpt_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [tlbpt_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic [tlbpt_pkg::RSP_USER_W-1:0]  rsp_tuser
);

   import tlbpt_pkg::*;

   // Stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   a_hit_fault_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[USER_HIT] && rsp_tuser[USER_FAULT]))
      else $error("hit and fault flagged together");

   a_fault_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[USER_FAULT] |-> rsp_tdata[FAULT_TOT_LSB +: 16] != 16'd0)
      else $error("fault reported with zero fault total");

   a_hit_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[USER_HIT] |-> rsp_tdata[HIT_TOT_LSB +: 16] != 16'd0)
      else $error("hit reported with zero hit total");

   // Reset empties the output and starts the page table sweep
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("channels active right after reset");

endmodule

bind tlb_page_table_translator tlbpt_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ----- tb/tlb_translation_checker.sv -----
// Checker for the TLB translator: predicts every translation and compares the returned fields.
module tlb_translation_checker
   import tlbpt_pkg::*;
#(
   parameter int TLB_ENTRIES = 16,
   parameter int PAGE_COUNT  = 256,
   parameter int PAGE_SIZE   = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic [RSP_USER_W-1:0] rsp_tuser,
   output int                    fail_count,
   output int                    pending_count,
   output int                    result_count,
   output int                    hit_count,
   output int                    fault_count,
   output int                    refill_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [ADDR_W-1:0]  phys;
      logic [FRAME_W-1:0] frame;
      logic               hit;
      logic               fault;
      logic [CNT_W-1:0]   hit_total;
      logic [CNT_W-1:0]   fault_total;
   } translation_t;

   // Predictor state: cached translations, page table and running tallies
   logic [TAG_W-1:0]   cached_page  [TLB_ENTRIES];
   logic [FRAME_W-1:0] cached_frame [TLB_ENTRIES];
   logic               cached_valid [TLB_ENTRIES];
   logic [FRAME_W-1:0] mapped_frame [PAGE_COUNT];
   logic               page_mapped  [PAGE_COUNT];
   logic [FREE_W-1:0]  free_frame;
   int                 refill_slot;
   logic [CNT_W-1:0]   hit_tally;
   logic [CNT_W-1:0]   fault_tally;

   translation_t translation_q[$];

   int mismatch_total = 0;
   int checked_total  = 0;
   int hits_seen      = 0;
   int faults_seen    = 0;
   int refills_seen   = 0;

   task automatic report_mismatch(input string what, input int unsigned want,
                                  input int unsigned got);
      $display("translation %0d: %s expected 0x%0h, got 0x%0h",
               checked_total, what, want, got);
      mismatch_total++;
   endtask

   function automatic translation_t translate(input logic [ADDR_W-1:0] addr);
      int unsigned  page;
      int unsigned  offset;
      int unsigned  frame;
      int           slot;
      translation_t t;
      page   = (addr / PAGE_SIZE) % PAGE_COUNT;
      offset = addr % PAGE_SIZE;
      frame  = 0;
      slot   = -1;
      t      = '0;
      // lowest matching entry wins
      for (int i = 0; i < TLB_ENTRIES; i++) begin
         if (slot < 0 && cached_valid[i] && cached_page[i] == TAG_W'(page))
            slot = i;
      end
      if (slot >= 0) begin
         t.hit = 1'b1;
         frame = cached_frame[slot];
         if (hit_tally != CNT_MAX) hit_tally++;
      end else begin
         if (page_mapped[page]) begin
            frame = mapped_frame[page];
         end else begin
            // demand-allocate: frame number wraps, free pointer saturates
            t.fault = 1'b1;
            frame = free_frame[FRAME_W-1:0];
            mapped_frame[page] = FRAME_W'(frame);
            page_mapped[page]  = 1'b1;
            if (free_frame != FREE_MAX) free_frame++;
            if (fault_tally != CNT_MAX) fault_tally++;
         end
         if (refill_slot >= TLB_ENTRIES) refill_slot = 0;
         cached_page[refill_slot]  = TAG_W'(page);
         cached_frame[refill_slot] = FRAME_W'(frame);
         cached_valid[refill_slot] = 1'b1;
         refill_slot = (refill_slot + 1) % TLB_ENTRIES;
      end
      t.phys        = ADDR_W'(frame * PAGE_SIZE + offset);
      t.frame       = FRAME_W'(frame);
      t.hit_total   = hit_tally;
      t.fault_total = fault_tally;
      return t;
   endfunction

   always @(posedge clock) begin : watch_channels
      translation_t want;
      if (reset) begin
         for (int i = 0; i < TLB_ENTRIES; i++) begin
            cached_page[i]  = '0;
            cached_frame[i] = '0;
            cached_valid[i] = 1'b0;
         end
         for (int p = 0; p < PAGE_COUNT; p++) begin
            mapped_frame[p] = '0;
            page_mapped[p]  = 1'b0;
         end
         free_frame  = '0;
         refill_slot = 0;
         hit_tally   = '0;
         fault_tally = '0;
         translation_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (translation_q.size() == 0) begin
               report_mismatch("transfer with no translation pending", 0, 0);
            end else begin
               want = translation_q.pop_front();
               if (rsp_tdata[PHYS_LSB +: ADDR_W] != want.phys)
                  report_mismatch("physical_address", want.phys,
                                  rsp_tdata[PHYS_LSB +: ADDR_W]);
               if (rsp_tdata[FRAME_LSB +: FRAME_W] != want.frame)
                  report_mismatch("frame_number", want.frame,
                                  rsp_tdata[FRAME_LSB +: FRAME_W]);
               if (rsp_tuser[USER_HIT] !== want.hit)
                  report_mismatch("tlb_hit", want.hit, rsp_tuser[USER_HIT]);
               if (rsp_tuser[USER_FAULT] !== want.fault)
                  report_mismatch("page_fault", want.fault, rsp_tuser[USER_FAULT]);
               if (rsp_tdata[HIT_TOT_LSB +: CNT_W] != want.hit_total)
                  report_mismatch("hit_total", want.hit_total,
                                  rsp_tdata[HIT_TOT_LSB +: CNT_W]);
               if (rsp_tdata[FAULT_TOT_LSB +: CNT_W] != want.fault_total)
                  report_mismatch("fault_total", want.fault_total,
                                  rsp_tdata[FAULT_TOT_LSB +: CNT_W]);
               if (want.hit) hits_seen++;
               else if (want.fault) faults_seen++;
               else refills_seen++;
            end
            checked_total++;
         end
         if (req_tvalid && req_tready)
            translation_q.push_back(translate(req_tdata[ADDR_W-1:0]));
      end
      fail_count    <= mismatch_total;
      pending_count <= translation_q.size();
      result_count  <= checked_total;
      hit_count     <= hits_seen;
      fault_count   <= faults_seen;
      refill_count  <= refills_seen;
   end

endmodule

// ----- tb/tlb_page_table_translator_tb.sv -----
// Stimulus, idle patterns, watchdog and verdict for the TLB page table translator.
module tlb_page_table_translator_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tlbpt_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int HOT_PAGES   = 24;
   localparam int PHASE_ITEMS = 267;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;  // logical_address[15:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // physical_address[15:0], frame_number[23:16], hit_total[39:24], fault_total[55:40]
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;  // tlb_hit[0], page_fault[1]

   int fail_count;
   int pending_count;
   int result_count;
   int hit_count;
   int fault_count;
   int refill_count;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int quiet_cycles  = 0;

   logic [7:0] hot_pages [HOT_PAGES];

   tlb_page_table_translator DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   tlb_translation_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .result_count  (result_count),
      .hit_count     (hit_count),
      .fault_count   (fault_count),
      .refill_count  (refill_count)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // End the run once neither channel has moved a transfer for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
         $display("tlb_page_table_translator_tb NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_address(input logic [ADDR_W-1:0] addr);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= addr;
      do @(posedge clock); while (!req_tready);
   endtask

   // Hold off new requests until every translation has come back
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic run_phase(input int count, input int send_pct, input int stall_pct,
                            input int pause_at);
      logic [ADDR_W-1:0] addr;
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      for (int n = 0; n < count; n++) begin
         if (n == pause_at) wait_for_drain();
         // mostly a working set a bit larger than the TLB, so hits and evictions mix
         if ($urandom_range(99) < 60) begin
            addr = {hot_pages[$urandom_range(HOT_PAGES-1)], 8'($urandom())};
         end else begin
            addr = ADDR_W'($urandom());
            hot_pages[$urandom_range(HOT_PAGES-1)] = addr[15:8];
         end
         send_address(addr);
      end
   endtask

   initial begin
      for (int i = 0; i < HOT_PAGES; i++) hot_pages[i] = 8'(i * 11);
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // page 0 against the empty TLB, then a hit on it; same for the top page
      send_address(16'h0000);
      send_address(16'h00FF);
      send_address(16'hFFFF);
      send_address(16'hFF00);
      // sixteen fresh pages push both out of the TLB
      for (int p = 1; p <= 16; p++) send_address({8'(p), 8'(p * 37)});
      // evicted pages 0 and 0xFF come back from the page table without a fault; 0x80 and 0x7F are new
      send_address(16'h0012);
      send_address(16'h8055);
      send_address(16'hFF80);
      send_address(16'h8000);
      send_address(16'h7FFF);

      run_phase(PHASE_ITEMS, 11, 54, 130);
      run_phase(PHASE_ITEMS, 54, 11, -1);
      run_phase(PHASE_ITEMS, 0, 0, -1);

      wait_for_drain();
      repeat (8) @(posedge clock);

      $display("checked %0d translations: %0d TLB hits, %0d page faults, %0d table refills",
               result_count, hit_count, fault_count, refill_count);
      $display("idle mixes: light sender/heavy receiver, the reverse, then back to back");
      if (fail_count == 0 && pending_count == 0) begin
         $display("tlb_page_table_translator_tb OK");
      end else begin
         $display("tlb_page_table_translator_tb NOT OK");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/tlbpt_pkg.sv
rtl/tlbpt_ram.sv
rtl/tlb_page_table_translator.sv
rtl/tlbpt_checker.sv
tb/tlb_translation_checker.sv
tb/tlb_page_table_translator_tb.sv
